// ----- rtl/staggered_curl_field_update_top_defines.svh -----
// ---------------------------------------------------------------------------
// staggered curl field update assertion macros
// shared assertion wrappers, empty when synthesised
// ---------------------------------------------------------------------------
`ifndef STAGGERED_CURL_FIELD_UPDATE_TOP_DEFINES_SVH
`define STAGGERED_CURL_FIELD_UPDATE_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define SCUR_ASSERT_HOLD(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define SCUR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define SCUR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SCUR_ASSERT_HOLD(lbl, cond, msg)
`define SCUR_ASSERT_IMPL(lbl, ante, cons, msg)
`define SCUR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ----- rtl/scur_pkg.sv -----
// ---------------------------------------------------------------------------
// scur_pkg
// widths, register indexes and pipeline control types of the field update
// ---------------------------------------------------------------------------
package scur_pkg;

  localparam int E_W     = 32;
  localparam int RATIO_W = 16;
  localparam int PTS_W   = 7;
  localparam int IDX_W   = 3;
  localparam int CFG_W   = 16;
  localparam int DIFF_W  = E_W + 1;
  localparam int PROD_W  = DIFF_W + RATIO_W + 1;
  localparam int SUM_W   = PROD_W + 1;
  localparam int SH_W    = SUM_W - 16;

  localparam logic [PTS_W-1:0] PTS_RESET = 7'd64;

  localparam logic [IDX_W-1:0] REG_RATIO_X  = 3'd0;
  localparam logic [IDX_W-1:0] REG_RATIO_Y  = 3'd1;
  localparam logic [IDX_W-1:0] REG_RATIO_Z  = 3'd2;
  localparam logic [IDX_W-1:0] REG_POINTS_X = 3'd3;
  localparam logic [IDX_W-1:0] REG_POINTS_Y = 3'd4;
  localparam logic [IDX_W-1:0] REG_POINTS_Z = 3'd5;
  localparam logic [IDX_W-1:0] REG_TWO_D    = 3'd6;

  localparam logic signed [E_W-1:0] E_MAX = 32'sh7fff_ffff;
  localparam logic signed [E_W-1:0] E_MIN = 32'sh8000_0000;

  // stage enables of the arithmetic lanes
  typedef struct packed {
    logic a;
    logic b;
    logic c;
    logic d;
  } adv_t;

endpackage

// ----- rtl/staggered_curl_field_update_top.sv -----
// ---------------------------------------------------------------------------
// staggered_curl_field_update_top
// streaming Faraday update of face fields on a staggered grid
// ---------------------------------------------------------------------------
// Grid points enter on the s_ channel in descending raster order (i outermost,
// k innermost), one beat per point carrying E and face B. Each beat yields one
// beat on the m_ channel with the updated B, a clip flag in m_tuser and
// m_tlast on the final point (0,0,0) of a grid.
// Registers are to be written on the cfg channel (cfg_ready is always high)
// only while the block is idle; the block does not check it. A write to a
// points register or to two_d restarts the scan at the last indices;
// s_tready is low for one cycle after it. Neighbour E values come from a plane
// memory indexed by (j,k) and a row memory indexed by k, both read and written
// in the accept cycle with a registered read, so no interlock is needed.
// Registers from input beat to output beat: memory read, difference,
// multiply, sum and shift, subtract and saturate.
// Throughput: one point per cycle while m_tready is high and no rescan is
// pending; each stage holds its beat only while the stage after it is full,
// so a stalled receiver fills the pipeline before s_tready drops.
// Reset: ratios 0, points 64, 3D mode, scan at the last indices; memory
// contents are not cleared and are only used where written in the same grid.
// ---------------------------------------------------------------------------
`include "staggered_curl_field_update_top_defines.svh"

module staggered_curl_field_update_top #(
  parameter int MAX_POINTS = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // e_x, e_y, e_z, b_x_in, b_y_in, b_z_in
  input  logic [6*scur_pkg::E_W-1:0]       s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // b_x_out, b_y_out, b_z_out
  output logic [3*scur_pkg::E_W-1:0]       m_tdata,
  // clipped
  output logic                             m_tuser,
  output logic                             m_tlast,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [scur_pkg::IDX_W-1:0]       cfg_index,
  input  logic [scur_pkg::CFG_W-1:0]       cfg_data
);

  localparam int IW     = $clog2(MAX_POINTS);
  localparam int PDEPTH = 1 << (2 * IW);
  localparam int RDEPTH = 1 << IW;
  localparam int EW     = scur_pkg::E_W;

  function automatic logic [IW-1:0] last_of(input logic [scur_pkg::PTS_W-1:0] p);
    logic [8:0] pw;
    pw = {2'b00, p};
    if (pw < 9'd2) begin
      last_of = IW'(1);
    end else if (pw > 9'(MAX_POINTS)) begin
      last_of = IW'(MAX_POINTS - 1);
    end else begin
      last_of = IW'(pw - 9'd1);
    end
  endfunction

  // configuration
  logic [scur_pkg::RATIO_W-1:0] ratio_x, ratio_y, ratio_z;
  logic [scur_pkg::PTS_W-1:0]   points_x, points_y, points_z;
  logic                         two_d;
  logic                         rescan;
  logic                         cfg_acc, geo_wr;

  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign geo_wr    = cfg_acc && (cfg_index == scur_pkg::REG_POINTS_X ||
                                 cfg_index == scur_pkg::REG_POINTS_Y ||
                                 cfg_index == scur_pkg::REG_POINTS_Z ||
                                 cfg_index == scur_pkg::REG_TWO_D);

  always_ff @(posedge clk) begin
    if (rst) begin
      ratio_x  <= '0;
      ratio_y  <= '0;
      ratio_z  <= '0;
      points_x <= scur_pkg::PTS_RESET;
      points_y <= scur_pkg::PTS_RESET;
      points_z <= scur_pkg::PTS_RESET;
      two_d    <= 1'b0;
      rescan   <= 1'b1;
    end else begin
      if (cfg_acc) begin
        case (cfg_index)
          scur_pkg::REG_RATIO_X:  ratio_x  <= cfg_data[scur_pkg::RATIO_W-1:0];
          scur_pkg::REG_RATIO_Y:  ratio_y  <= cfg_data[scur_pkg::RATIO_W-1:0];
          scur_pkg::REG_RATIO_Z:  ratio_z  <= cfg_data[scur_pkg::RATIO_W-1:0];
          scur_pkg::REG_POINTS_X: points_x <= cfg_data[scur_pkg::PTS_W-1:0];
          scur_pkg::REG_POINTS_Y: points_y <= cfg_data[scur_pkg::PTS_W-1:0];
          scur_pkg::REG_POINTS_Z: points_z <= cfg_data[scur_pkg::PTS_W-1:0];
          scur_pkg::REG_TWO_D:    two_d    <= cfg_data[0];
          default: ;
        endcase
      end
      if (geo_wr) begin
        rescan <= 1'b1;
      end else if (rescan) begin
        rescan <= 1'b0;
      end
    end
  end

  logic [IW-1:0] last_i, last_j, last_k;

  assign last_i = last_of(points_x);
  assign last_j = last_of(points_y);
  assign last_k = two_d ? '0 : last_of(points_z);

  // pipeline control
  logic v1, va, vb, vc, vo;
  logic en_1, en_a, en_b, en_c, en_o;
  logic s_acc;
  scur_pkg::adv_t adv;

  assign en_o     = !vo || m_tready;
  assign en_c     = !vc || en_o;
  assign en_b     = !vb || en_c;
  assign en_a     = !va || en_b;
  assign en_1     = !v1 || en_a;
  assign s_tready = en_1 && !rescan;
  assign s_acc    = s_tvalid && s_tready;
  assign adv      = '{a: en_a, b: en_b, c: en_c, d: en_o};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      vo <= 1'b0;
    end else begin
      if (en_1) v1 <= s_acc;
      if (en_a) va <= v1;
      if (en_b) vb <= va;
      if (en_c) vc <= vb;
      if (en_o) vo <= vc;
    end
  end

  // scan position
  logic [IW-1:0] pos_i, pos_j, pos_k;

  always_ff @(posedge clk) begin
    if (rescan) begin
      pos_i <= last_i;
      pos_j <= last_j;
      pos_k <= last_k;
    end else if (s_acc) begin
      if (pos_k != '0) begin
        pos_k <= pos_k - IW'(1);
      end else begin
        pos_k <= last_k;
        if (pos_j != '0) begin
          pos_j <= pos_j - IW'(1);
        end else begin
          pos_j <= last_j;
          pos_i <= (pos_i != '0) ? pos_i - IW'(1) : last_i;
        end
      end
    end
  end

  // input fields
  logic signed [EW-1:0] in_ex, in_ey, in_ez;

  assign in_ex = s_tdata[EW-1:0];
  assign in_ey = s_tdata[2*EW-1:EW];
  assign in_ez = s_tdata[3*EW-1:2*EW];

  // neighbour memories
  logic [2*EW-1:0] plane_store [PDEPTH];
  logic [2*EW-1:0] row_store   [RDEPTH];
  logic [2*EW-1:0] pl_rd, rw_rd;
  logic [2*IW-1:0] p_addr;

  assign p_addr = {pos_j, pos_k};

  always_ff @(posedge clk) begin
    if (s_acc) begin
      plane_store[p_addr] <= {in_ez, in_ey};
      pl_rd               <= plane_store[p_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc) begin
      row_store[pos_k] <= {in_ez, in_ex};
      rw_rd            <= row_store[pos_k];
    end
  end

  // first stage payload
  logic [2*EW-1:0]      prev_point, prev_1;
  logic signed [EW-1:0] ex_1, ey_1, ez_1, bx_1, by_1, bz_1;
  logic                 upd_x, upd_y, upd_z, done_1;
  logic                 has_i, has_j, has_k;
  logic                 done_a, done_b, done_c;

  assign has_i = pos_i != last_i;
  assign has_j = pos_j != last_j;
  assign has_k = !two_d && pos_k != last_k;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_point <= '0;
    end else if (s_acc) begin
      prev_point <= {in_ey, in_ex};
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc) begin
      prev_1 <= prev_point;
      ex_1   <= in_ex;
      ey_1   <= in_ey;
      ez_1   <= in_ez;
      bx_1   <= s_tdata[4*EW-1:3*EW];
      by_1   <= s_tdata[5*EW-1:4*EW];
      bz_1   <= s_tdata[6*EW-1:5*EW];
      upd_x  <= has_j && (two_d || has_k);
      upd_y  <= has_i && (two_d || has_k);
      upd_z  <= has_i && has_j;
      done_1 <= pos_i == '0 && pos_j == '0 && pos_k == '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) done_a <= done_1;
    if (en_b) done_b <= done_a;
    if (en_c) done_c <= done_b;
    if (en_o) m_tlast <= done_c;
  end

  // component lanes
  logic signed [EW-1:0] bx_o, by_o, bz_o;
  logic                 clip_x, clip_y, clip_z;

  scur_lane u_lane_x (
    .clk   (clk),
    .adv   (adv),
    .b     (bx_1),
    .n_a   (rw_rd[2*EW-1:EW]),
    .h_a   (ez_1),
    .r_a   (ratio_y),
    .use_a (1'b1),
    .n_b   (prev_1[2*EW-1:EW]),
    .h_b   (ey_1),
    .r_b   (ratio_z),
    .use_b (!two_d),
    .upd   (upd_x),
    .value (bx_o),
    .clip  (clip_x)
  );

  scur_lane u_lane_y (
    .clk   (clk),
    .adv   (adv),
    .b     (by_1),
    .n_a   (prev_1[EW-1:0]),
    .h_a   (ex_1),
    .r_a   (ratio_z),
    .use_a (!two_d),
    .n_b   (pl_rd[2*EW-1:EW]),
    .h_b   (ez_1),
    .r_b   (ratio_x),
    .use_b (1'b1),
    .upd   (upd_y),
    .value (by_o),
    .clip  (clip_y)
  );

  scur_lane u_lane_z (
    .clk   (clk),
    .adv   (adv),
    .b     (bz_1),
    .n_a   (pl_rd[EW-1:0]),
    .h_a   (ey_1),
    .r_a   (ratio_x),
    .use_a (1'b1),
    .n_b   (rw_rd[EW-1:0]),
    .h_b   (ex_1),
    .r_b   (ratio_y),
    .use_b (1'b1),
    .upd   (upd_z),
    .value (bz_o),
    .clip  (clip_z)
  );

  assign m_tvalid = vo;
  assign m_tdata  = {bz_o, by_o, bx_o};
  assign m_tuser  = clip_x || clip_y || clip_z;

  // checks
  `SCUR_ASSERT_IMPL(a_pos_bound, !rescan, pos_i <= last_i && pos_j <= last_j && pos_k <= last_k, "scan position beyond grid")
  `SCUR_ASSERT_IMPL(a_planar_k, !rescan && two_d, pos_k == '0, "k index moved in planar mode")
  `SCUR_ASSERT_NEXT(a_wrap, s_acc && !cfg_valid && pos_i == '0 && pos_j == '0 && pos_k == '0, pos_i == last_i && pos_j == last_j && pos_k == last_k, "scan did not wrap after final point")
  `SCUR_ASSERT_IMPL(a_clip_value, vo && m_tuser, bx_o == scur_pkg::E_MAX || bx_o == scur_pkg::E_MIN || by_o == scur_pkg::E_MAX || by_o == scur_pkg::E_MIN || bz_o == scur_pkg::E_MAX || bz_o == scur_pkg::E_MIN, "clip flag without a saturated component")

endmodule

// ----- rtl/scur_lane.sv -----
// ---------------------------------------------------------------------------
// scur_lane
// one field component: b - floor((da*ra - db*rb) / 2^16), saturated
// ---------------------------------------------------------------------------
module scur_lane (
  input  logic                                   clk,
  input  scur_pkg::adv_t                         adv,
  input  logic signed [scur_pkg::E_W-1:0]        b,
  input  logic signed [scur_pkg::E_W-1:0]        n_a,
  input  logic signed [scur_pkg::E_W-1:0]        h_a,
  input  logic        [scur_pkg::RATIO_W-1:0]    r_a,
  input  logic                                   use_a,
  input  logic signed [scur_pkg::E_W-1:0]        n_b,
  input  logic signed [scur_pkg::E_W-1:0]        h_b,
  input  logic        [scur_pkg::RATIO_W-1:0]    r_b,
  input  logic                                   use_b,
  input  logic                                   upd,
  output logic signed [scur_pkg::E_W-1:0]        value,
  output logic                                   clip
);

  logic signed [scur_pkg::DIFF_W-1:0]  da, db;
  logic signed [scur_pkg::E_W-1:0]     b_a, b_b, b_c;
  logic                                upd_a, upd_b, upd_c;
  logic                                ua, ub;
  logic signed [scur_pkg::PROD_W-1:0]  pa, pb;
  logic signed [scur_pkg::SH_W-1:0]    sh;
  logic signed [scur_pkg::SUM_W-1:0]   sum;
  logic signed [scur_pkg::E_W+3:0]     r;
  logic                                sat;
  logic signed [scur_pkg::RATIO_W:0]   ra_s, rb_s;

  assign ra_s = $signed({1'b0, r_a});
  assign rb_s = $signed({1'b0, r_b});

  // differences
  always_ff @(posedge clk) begin
    if (adv.a) begin
      da    <= {n_a[scur_pkg::E_W-1], n_a} - {h_a[scur_pkg::E_W-1], h_a};
      db    <= {n_b[scur_pkg::E_W-1], n_b} - {h_b[scur_pkg::E_W-1], h_b};
      ua    <= use_a;
      ub    <= use_b;
      b_a   <= b;
      upd_a <= upd;
    end
  end

  // products
  always_ff @(posedge clk) begin
    if (adv.b) begin
      pa    <= ua ? da * ra_s : $signed({scur_pkg::PROD_W{1'b0}});
      pb    <= ub ? db * rb_s : $signed({scur_pkg::PROD_W{1'b0}});
      b_b   <= b_a;
      upd_b <= upd_a;
    end
  end

  // exact sum, floor shift
  assign sum = {pa[scur_pkg::PROD_W-1], pa} - {pb[scur_pkg::PROD_W-1], pb};

  always_ff @(posedge clk) begin
    if (adv.c) begin
      sh    <= sum[scur_pkg::SUM_W-1:16];
      b_c   <= b_b;
      upd_c <= upd_b;
    end
  end

  // subtract and saturate
  always_comb begin
    r   = {{4{b_c[scur_pkg::E_W-1]}}, b_c} - {sh[scur_pkg::SH_W-1], sh};
    sat = (r[scur_pkg::E_W+3:scur_pkg::E_W-1] != '0) &&
          (r[scur_pkg::E_W+3:scur_pkg::E_W-1] != '1);
  end

  always_ff @(posedge clk) begin
    if (adv.d) begin
      if (!upd_c) begin
        value <= b_c;
      end else if (sat) begin
        value <= r[scur_pkg::E_W+3] ? scur_pkg::E_MIN : scur_pkg::E_MAX;
      end else begin
        value <= r[scur_pkg::E_W-1:0];
      end
      clip <= upd_c && sat;
    end
  end

endmodule

// ----- bench/face_field_checker.sv -----
// ---------------------------------------------------------------------------
// face field checker
// follows the configuration writes and the grid point beats of the field
// update, predicts the updated face field of every point and compares it
// field by field with the result beats, oldest first
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module face_field_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  input  logic                         s_tready,
  // e_x, e_y, e_z, b_x_in, b_y_in, b_z_in
  input  logic [6*scur_pkg::E_W-1:0]   s_tdata,
  input  logic                         m_tvalid,
  input  logic                         m_tready,
  // b_x_out, b_y_out, b_z_out
  input  logic [3*scur_pkg::E_W-1:0]   m_tdata,
  // clipped
  input  logic                         m_tuser,
  input  logic                         m_tlast,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [scur_pkg::IDX_W-1:0]   cfg_index,
  input  logic [scur_pkg::CFG_W-1:0]   cfg_data,
  output int                           fail_count,
  output int                           pending
);
  import scur_pkg::*;

  localparam int     GRID_MAX = 64;
  localparam longint SAT_HI   = 64'sd2147483647;
  localparam longint SAT_LO   = -64'sd2147483648;

  typedef struct packed {
    logic [E_W-1:0] b_x;
    logic [E_W-1:0] b_y;
    logic [E_W-1:0] b_z;
    logic           clipped;
    logic           grid_done;
  } face_field_t;

  face_field_t updated_b_due[$];

  logic signed [E_W-1:0] plane_ey [GRID_MAX*GRID_MAX];
  logic signed [E_W-1:0] plane_ez [GRID_MAX*GRID_MAX];
  logic signed [E_W-1:0] row_ex   [GRID_MAX];
  logic signed [E_W-1:0] row_ez   [GRID_MAX];
  logic signed [E_W-1:0] prev_ex;
  logic signed [E_W-1:0] prev_ey;
  int     pos_i, pos_j, pos_k;
  longint ratio_x, ratio_y, ratio_z;
  int     points_x, points_y, points_z;
  bit     planar;

  function automatic int span(int pts);
    if (pts < 2) return 2;
    if (pts > GRID_MAX) return GRID_MAX;
    return pts;
  endfunction

  function automatic longint saturate(longint v);
    if (v > SAT_HI) return SAT_HI;
    if (v < SAT_LO) return SAT_LO;
    return v;
  endfunction

  function automatic bit out_of_word(longint v);
    return v > SAT_HI || v < SAT_LO;
  endfunction

  function void restart_scan();
    pos_i = span(points_x) - 1;
    pos_j = span(points_y) - 1;
    pos_k = planar ? 0 : span(points_z) - 1;
  endfunction

  function void write_register(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    case (idx)
      REG_RATIO_X: ratio_x = data;
      REG_RATIO_Y: ratio_y = data;
      REG_RATIO_Z: ratio_z = data;
      REG_POINTS_X: begin
        points_x = data[PTS_W-1:0];
        restart_scan();
      end
      REG_POINTS_Y: begin
        points_y = data[PTS_W-1:0];
        restart_scan();
      end
      REG_POINTS_Z: begin
        points_z = data[PTS_W-1:0];
        restart_scan();
      end
      REG_TWO_D: begin
        planar = data[0];
        restart_scan();
      end
      default: ;
    endcase
  endfunction

  function void predict_face_update(logic [6*E_W-1:0] beat);
    longint ex, ey, ez, bx, by, bz;
    longint pl_ey, pl_ez, rw_ex, rw_ez, pv_ex, pv_ey;
    longint sum_x, sum_y, sum_z, ox, oy, oz;
    int li, lj, lk, i, j, k, pidx;
    bit has_i, has_j, has_k;
    face_field_t r;
    li = span(points_x) - 1;
    lj = span(points_y) - 1;
    lk = planar ? 0 : span(points_z) - 1;
    ex = $signed(beat[0*E_W +: E_W]);
    ey = $signed(beat[1*E_W +: E_W]);
    ez = $signed(beat[2*E_W +: E_W]);
    bx = $signed(beat[3*E_W +: E_W]);
    by = $signed(beat[4*E_W +: E_W]);
    bz = $signed(beat[5*E_W +: E_W]);
    if (pos_i > li) pos_i = li;
    if (pos_j > lj) pos_j = lj;
    if (pos_k > lk) pos_k = lk;
    i = pos_i;
    j = pos_j;
    k = pos_k;
    pidx = j * GRID_MAX + k;
    has_i = i < li;
    has_j = j < lj;
    has_k = !planar && k < lk;
    pl_ey = 0;
    pl_ez = 0;
    rw_ex = 0;
    rw_ez = 0;
    if (has_i) begin
      pl_ey = plane_ey[pidx];
      pl_ez = plane_ez[pidx];
    end
    if (has_j) begin
      rw_ex = row_ex[k];
      rw_ez = row_ez[k];
    end
    pv_ex = prev_ex;
    pv_ey = prev_ey;
    ox = bx;
    oy = by;
    oz = bz;
    if (has_j && (planar || has_k)) begin
      sum_x = (rw_ez - ez) * ratio_y - (planar ? 64'sd0 : (pv_ey - ey) * ratio_z);
      ox = bx - (sum_x >>> 16);
    end
    if (has_i && (planar || has_k)) begin
      sum_y = (planar ? 64'sd0 : (pv_ex - ex) * ratio_z) - (pl_ez - ez) * ratio_x;
      oy = by - (sum_y >>> 16);
    end
    if (has_i && has_j) begin
      sum_z = (pl_ey - ey) * ratio_x - (rw_ex - ex) * ratio_y;
      oz = bz - (sum_z >>> 16);
    end
    // untouched components are always inside the word
    r.clipped   = out_of_word(ox) || out_of_word(oy) || out_of_word(oz);
    r.b_x       = E_W'(saturate(ox));
    r.b_y       = E_W'(saturate(oy));
    r.b_z       = E_W'(saturate(oz));
    r.grid_done = (i == 0 && j == 0 && k == 0);
    updated_b_due.push_back(r);

    plane_ey[pidx] = ey;
    plane_ez[pidx] = ez;
    row_ex[k]      = ex;
    row_ez[k]      = ez;
    prev_ex        = ex;
    prev_ey        = ey;

    if (k > 0) begin
      pos_k = k - 1;
    end else begin
      pos_k = lk;
      if (j > 0) begin
        pos_j = j - 1;
      end else begin
        pos_j = lj;
        pos_i = (i > 0) ? i - 1 : li;
      end
    end
  endfunction

  function void check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s expected %0d got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    face_field_t want;
    if (rst) begin
      updated_b_due.delete();
      fail_count = 0;
      ratio_x    = 0;
      ratio_y    = 0;
      ratio_z    = 0;
      points_x   = PTS_RESET;
      points_y   = PTS_RESET;
      points_z   = PTS_RESET;
      planar     = 1'b0;
      prev_ex    = '0;
      prev_ey    = '0;
      restart_scan();
    end else begin
      if (m_tvalid && m_tready) begin
        if ($isunknown({m_tdata, m_tuser, m_tlast})) begin
          $error("result beat carries unknown bits: %h %b %b", m_tdata, m_tuser, m_tlast);
          fail_count++;
        end
        if (updated_b_due.size() == 0) begin
          $error("result beat with no grid point waiting");
          fail_count++;
        end else begin
          want = updated_b_due.pop_front();
          check_field("b_x_out", $signed(want.b_x), $signed(m_tdata[0*E_W +: E_W]));
          check_field("b_y_out", $signed(want.b_y), $signed(m_tdata[1*E_W +: E_W]));
          check_field("b_z_out", $signed(want.b_z), $signed(m_tdata[2*E_W +: E_W]));
          check_field("clipped", want.clipped, m_tuser);
          check_field("grid_done", want.grid_done, m_tlast);
        end
      end
      if (cfg_valid && cfg_ready) write_register(cfg_index, cfg_data);
      if (s_tvalid && s_tready) predict_face_update(s_tdata);
    end
    pending = updated_b_due.size();
  end

endmodule

// ----- bench/testbench.sv -----
// ---------------------------------------------------------------------------
// staggered curl field update testbench
// streams grid points through the field update under bursty input and a
// stalling receiver, over several grid shapes and step ratios, and leaves
// prediction and comparison to the face field checker
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import scur_pkg::*;

  localparam int WORD_WIDE = 0;
  localparam int WORD_NEAR = 1;
  localparam int WORD_EDGE = 2;

  localparam int RX_OPEN    = 0;
  localparam int RX_COIN    = 1;
  localparam int RX_PATTERN = 2;
  localparam int RX_MOSTLY  = 3;

  localparam int HOLD_CYCLES = 100;
  localparam int ITEM_TARGET = 850;

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [6*E_W-1:0]    s_tdata;
  logic                m_tvalid;
  logic                m_tready;
  logic [3*E_W-1:0]    m_tdata;
  logic                m_tuser;
  logic                m_tlast;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [IDX_W-1:0]    cfg_index;
  logic [CFG_W-1:0]    cfg_data;
  int                  fail_count;
  int                  pending;

  int burst_left;
  int items_sent;
  bit hold_request;
  bit hold_finished;

  staggered_curl_field_update_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  face_field_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  initial begin
    #5_000_000;
    $display("staggered_curl_field_update_top verification failed");
    $finish;
  end

  function automatic logic [6*E_W-1:0] pack_point(logic [E_W-1:0] ex, logic [E_W-1:0] ey,
                                                   logic [E_W-1:0] ez, logic [E_W-1:0] bx,
                                                   logic [E_W-1:0] by, logic [E_W-1:0] bz);
    return {bz, by, bx, ez, ey, ex};
  endfunction

  function automatic logic [E_W-1:0] draw_word(int style);
    logic        sign;
    logic [19:0] low;
    sign = 1'($urandom_range(0, 1));
    low  = 20'($urandom);
    case (style)
      WORD_NEAR: return {{12{sign}}, low};
      WORD_EDGE: begin
        case ($urandom_range(0, 4))
          0: return E_MAX;
          1: return E_MIN;
          2: return '0;
          3: return 32'd1;
          default: return '1;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [6*E_W-1:0] draw_point();
    logic [6*E_W-1:0] beat;
    int pick, base, style, f;
    pick = $urandom_range(0, 19);
    base = (pick < 12) ? WORD_NEAR : ((pick < 17) ? WORD_WIDE : WORD_EDGE);
    for (f = 0; f < 6; f++) begin
      style = ($urandom_range(0, 7) == 0) ? $urandom_range(WORD_WIDE, WORD_EDGE) : base;
      beat[f*E_W +: E_W] = draw_word(style);
    end
    return beat;
  endfunction

  function automatic logic [CFG_W-1:0] draw_ratio();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return CFG_W'($urandom_range(1, 255));
      default: return CFG_W'($urandom);
    endcase
  endfunction

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // stop offering and let every outstanding result come back
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic set_ratios(input logic [CFG_W-1:0] rx, input logic [CFG_W-1:0] ry,
                            input logic [CFG_W-1:0] rz);
    drain();
    write_reg(REG_RATIO_X, rx);
    write_reg(REG_RATIO_Y, ry);
    write_reg(REG_RATIO_Z, rz);
  endtask

  task automatic set_shape(input int px, input int py, input int pz, input bit planar);
    drain();
    write_reg(REG_POINTS_X, CFG_W'(px));
    write_reg(REG_POINTS_Y, CFG_W'(py));
    write_reg(REG_POINTS_Z, CFG_W'(pz));
    write_reg(REG_TWO_D, CFG_W'(planar));
  endtask

  task automatic send_point(input logic [6*E_W-1:0] beat);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0 || (hold_request && !hold_finished)) ?
            0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= beat;
    do @(posedge clk); while (!s_tready);
    burst_left--;
  endtask

  task automatic run_points(input int count);
    repeat (count) send_point(draw_point());
    items_sent += count;
  endtask

  // receiver: changing stall patterns, plus one long hold-off on request
  initial begin : receiver
    int mode, mode_left, step, held;
    logic [15:0] pattern;
    m_tready      = 1'b0;
    hold_finished = 1'b0;
    mode_left     = 0;
    step          = 0;
    held          = 0;
    mode          = RX_OPEN;
    pattern       = '1;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (hold_request && !hold_finished) begin
        m_tready <= 1'b0;
        held++;
        if (held == HOLD_CYCLES) hold_finished = 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(RX_OPEN, RX_MOSTLY);
          mode_left = $urandom_range(20, 200);
          pattern   = 16'($urandom);
          step      = 0;
        end
        mode_left--;
        case (mode)
          RX_OPEN: m_tready <= 1'b1;
          RX_COIN: m_tready <= ($urandom_range(0, 1) == 1);
          RX_PATTERN: begin
            m_tready <= pattern[step];
            step = (step + 1) % 16;
          end
          default: m_tready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    int n, px, py, pz;
    bit planar;
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    burst_left   = 0;
    items_sent   = 0;
    hold_request = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // smallest 3d grid, full ratios, extreme fields so that both ends clip
    set_ratios('1, '1, '1);
    set_shape(2, 2, 2, 1'b0);
    for (n = 0; n < 8; n++) begin
      send_point(pack_point(n[0] ? E_MIN : E_MAX, n[1] ? E_MAX : E_MIN,
                            (n % 3 == 0) ? E_MIN : E_MAX, n[1] ? E_MIN : E_MAX,
                            n[2] ? E_MAX : E_MIN, n[0] ? 32'd0 : E_MIN));
    end

    // planar grid, points_z below range and ignored
    set_ratios('1, 16'd1, 16'h8000);
    set_shape(3, 2, 0, 1'b1);
    for (n = 0; n < 6; n++) begin
      send_point(pack_point(E_MAX - n, -(n * 32'sh10000), n[0] ? E_MIN : 3 * n,
                            n[0] ? E_MAX : 32'd0, n[1] ? E_MIN : 32'd7,
                            (n == 4) ? E_MIN : E_MAX));
    end

    // zero ratios leave every face untouched, points below two act as two
    set_ratios('0, '0, '0);
    set_shape(1, 0, 2, 1'b0);
    run_points(8);
    items_sent = 0;

    // one long axis each, points above range act as the maximum
    set_ratios(draw_ratio(), draw_ratio(), draw_ratio());
    set_shape(127, 2, 40, 1'b1);
    run_points(128);
    set_ratios(draw_ratio(), draw_ratio(), draw_ratio());
    set_shape(2, 64, 0, 1'b1);
    run_points(128);
    set_ratios(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom));
    set_shape(2, 2, 64, 1'b0);
    hold_request = 1'b1;
    run_points(130);

    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 3) == 0) begin
        // ratios only: the scan carries on within the current grid
        set_ratios(draw_ratio(), draw_ratio(), draw_ratio());
      end else begin
        set_ratios(draw_ratio(), draw_ratio(), draw_ratio());
        planar = 1'($urandom_range(0, 1));
        px = $urandom_range(0, 5);
        py = $urandom_range(0, 5);
        pz = $urandom_range(0, 6);
        set_shape(px, py, pz, planar);
      end
      run_points($urandom_range(4, 100));
    end

    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("staggered_curl_field_update_top verification clean");
    end else begin
      $display("staggered_curl_field_update_top verification failed");
    end
    $finish;
  end

endmodule
